// ----- hw/rtl/i2cm_pkg.sv -----
// shared types and constants for the i2c byte engine
// item and result beat structs, command classes, queue sizes, register map
// no dependencies
package i2cm_pkg;

    // input function codes
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // configuration register map (index taken from paddr[2])
    localparam int          APB_AW     = 3;
    localparam logic        REG_HALF   = 1'b0;
    localparam logic        REG_POLL   = 1'b1;
    localparam logic [15:0] HALF_RESET = 16'd5;
    localparam logic [7:0]  POLL_RESET = 8'd15;

    // queue sizes (powers of two)
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    // input beat
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       sda_sample;
    } item_t;

    // result beat
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } res_t;

    // class of an accepted beat
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_WRITE,
        KIND_READ,
        KIND_NONE
    } kind_t;

    // classified beat handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       sda_sample;
    } cmd_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_poll_limit;
    } cfg_t;

endpackage

// ----- hw/rtl/i2cm_cfg.sv -----
// apb configuration registers for the i2c byte engine
// depends on i2cm_pkg
module i2cm_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [i2cm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output i2cm_pkg::cfg_t             cfg
);

    logic [15:0] half_reg;
    logic [7:0]  poll_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= i2cm_pkg::HALF_RESET;
            poll_reg <= i2cm_pkg::POLL_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == i2cm_pkg::REG_HALF)
            begin
                half_reg <= pwdata[15:0];
            end
            else
            begin
                poll_reg <= pwdata[7:0];
            end
        end
    end

    // read back
    always_comb
    begin
        if (paddr[2] == i2cm_pkg::REG_POLL)
        begin
            prdata = {24'd0, poll_reg};
        end
        else
        begin
            prdata = {16'd0, half_reg};
        end
    end

    assign cfg.half_period_ticks = half_reg;
    assign cfg.ack_poll_limit    = poll_reg;

endmodule

// ----- hw/rtl/i2cm_front.sv -----
// front end: accepts input beats, classifies them and queues them for the sequencer
// depends on i2cm_pkg
module i2cm_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  i2cm_pkg::item_t item,
    output logic            cmd_valid,
    output i2cm_pkg::cmd_t  cmd,
    input  logic            cmd_take
);

    i2cm_pkg::cmd_t                cmd_mem [i2cm_pkg::CMDQ_DEPTH];
    logic [i2cm_pkg::CMDQ_AW-1:0]  wr_ptr_reg;
    logic [i2cm_pkg::CMDQ_AW-1:0]  rd_ptr_reg;
    logic [i2cm_pkg::CMDQ_AW:0]    cnt_reg;
    logic [i2cm_pkg::CMDQ_AW:0]    cnt_next;
    logic                          in_take;
    i2cm_pkg::cmd_t                dec;

    // classify the incoming beat
    always_comb
    begin
        dec.data_byte  = item.data_byte;
        dec.last_byte  = item.last_byte;
        dec.sda_sample = item.sda_sample;
        case (item.func)
            i2cm_pkg::FUNC_TICK:  dec.kind = i2cm_pkg::KIND_TICK;
            i2cm_pkg::FUNC_START: dec.kind = i2cm_pkg::KIND_START;
            i2cm_pkg::FUNC_STOP:  dec.kind = i2cm_pkg::KIND_STOP;
            i2cm_pkg::FUNC_WRITE: dec.kind = i2cm_pkg::KIND_WRITE;
            i2cm_pkg::FUNC_READ:  dec.kind = i2cm_pkg::KIND_READ;
            default:              dec.kind = i2cm_pkg::KIND_NONE;
        endcase
    end

    assign full      = (cnt_reg == (i2cm_pkg::CMDQ_AW+1)'(i2cm_pkg::CMDQ_DEPTH));
    assign in_take   = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = cmd_mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        case ({in_take, cmd_take})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_mem[wr_ptr_reg] <= dec;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (i2cm_pkg::CMDQ_AW+1)'(i2cm_pkg::CMDQ_DEPTH))
        else $error("command queue overfilled");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");
    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !cmd_take) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("command queue count lost a beat");

endmodule

// ----- hw/rtl/i2cm_back.sv -----
// back end: bit-level bus sequencer, one queued beat per cycle while the result queue has room, plus result queue
// depends on i2cm_pkg
module i2cm_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  i2cm_pkg::cfg_t  cfg,
    input  logic            cmd_valid,
    input  i2cm_pkg::cmd_t  cmd,
    output logic            cmd_take,
    output logic            empty,
    input  logic            pop,
    output i2cm_pkg::res_t  result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_W_LOW,
        PH_W_HIGH,
        PH_W_ACKHI,
        PH_W_POLL,
        PH_R_LOW0,
        PH_R_HIGH,
        PH_R_LOW,
        PH_R_ACK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  poll_reg, poll_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        nack_reg, nack_next;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;

    logic        done;
    logic        rej;
    logic [15:0] half;
    logic [7:0]  lim;
    logic [16:0] tick_inc;
    logic        over;
    logic [15:0] tick_adv;
    logic [3:0]  bit_inc;
    logic [7:0]  poll_inc;

    i2cm_pkg::res_t               res_in;
    i2cm_pkg::res_t               res_mem [i2cm_pkg::RESQ_DEPTH];
    logic [i2cm_pkg::RESQ_AW-1:0] wr_ptr_reg;
    logic [i2cm_pkg::RESQ_AW-1:0] rd_ptr_reg;
    logic [i2cm_pkg::RESQ_AW:0]   cnt_reg;
    logic [i2cm_pkg::RESQ_AW:0]   cnt_next;
    logic                         res_full;
    logic                         res_pop;

    // phase timing helpers
    assign half     = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
    assign lim      = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign over     = (tick_inc >= {1'b0, half});
    assign tick_adv = over ? 16'd0 : tick_inc[15:0];
    assign bit_inc  = bit_reg + 4'd1;
    assign poll_inc = poll_reg + 8'd1;

    // sequencer next state
    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        rej        = 1'b0;
        case (cmd.kind)
            i2cm_pkg::KIND_TICK:
            begin
                if (phase_reg != PH_W_POLL)
                begin
                    tick_next = tick_adv;
                end
                case (phase_reg)
                    PH_IDLE:
                    begin
                        tick_next = tick_reg;
                    end
                    PH_START_A:
                    begin
                        if (over)
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_START_B;
                        end
                    end
                    PH_START_B:
                    begin
                        if (over)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_STOP_A:
                    begin
                        if (over)
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_STOP_B;
                        end
                    end
                    PH_STOP_B:
                    begin
                        if (over)
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_W_LOW:
                    begin
                        if (over)
                        begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            scl_next   = 1'b1;
                            phase_next = PH_W_HIGH;
                        end
                    end
                    PH_W_HIGH:
                    begin
                        if (over)
                        begin
                            bit_next = bit_inc;
                            if (bit_inc < 4'd8)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_W_LOW;
                            end
                            else
                            begin
                                sda_next   = 1'b1;
                                scl_next   = 1'b1;
                                phase_next = PH_W_ACKHI;
                            end
                        end
                    end
                    PH_W_ACKHI:
                    begin
                        if (over)
                        begin
                            poll_next  = 8'd0;
                            phase_next = PH_W_POLL;
                        end
                    end
                    PH_W_POLL:
                    begin
                        if (!cmd.sda_sample)
                        begin
                            ack_next   = 1'b1;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= lim)
                            begin
                                ack_next   = 1'b0;
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                    end
                    PH_R_LOW0:
                    begin
                        if (over)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_R_HIGH;
                        end
                    end
                    PH_R_HIGH:
                    begin
                        if (over)
                        begin
                            shift_next = {shift_reg[6:0], cmd.sda_sample};
                            scl_next   = 1'b0;
                            phase_next = PH_R_LOW;
                        end
                    end
                    PH_R_LOW:
                    begin
                        if (over)
                        begin
                            bit_next = bit_inc;
                            scl_next = 1'b1;
                            if (bit_inc < 4'd8)
                            begin
                                phase_next = PH_R_HIGH;
                            end
                            else
                            begin
                                rx_next    = shift_reg;
                                sda_next   = nack_reg;
                                phase_next = PH_R_ACK;
                            end
                        end
                    end
                    PH_R_ACK:
                    begin
                        if (over)
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            i2cm_pkg::KIND_START,
            i2cm_pkg::KIND_STOP,
            i2cm_pkg::KIND_WRITE,
            i2cm_pkg::KIND_READ:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    tick_next = 16'd0;
                    bit_next  = 4'd0;
                    case (cmd.kind)
                        i2cm_pkg::KIND_START:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_START_A;
                        end
                        i2cm_pkg::KIND_STOP:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                            phase_next = PH_STOP_A;
                        end
                        i2cm_pkg::KIND_WRITE:
                        begin
                            shift_next = cmd.data_byte;
                            scl_next   = 1'b0;
                            phase_next = PH_W_LOW;
                        end
                        default:
                        begin
                            shift_next = 8'd0;
                            nack_next  = cmd.last_byte;
                            sda_next   = 1'b1;
                            scl_next   = 1'b0;
                            phase_next = PH_R_LOW0;
                        end
                    endcase
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // result beat for this step
    assign res_in.scl_level = scl_next;
    assign res_in.sda_level = sda_next;
    assign res_in.busy_res  = (phase_next != PH_IDLE);
    assign res_in.done_res  = done;
    assign res_in.rx_byte   = rx_next;
    assign res_in.ack_seen  = ack_next;
    assign res_in.rejected  = rej;

    // handshakes around the result queue
    assign res_full = (cnt_reg == (i2cm_pkg::RESQ_AW+1)'(i2cm_pkg::RESQ_DEPTH));
    assign cmd_take = cmd_valid && !res_full;
    assign empty    = (cnt_reg == '0);
    assign res_pop  = pop && !empty;
    assign result   = res_mem[rd_ptr_reg];

    // result queue occupancy
    always_comb
    begin
        case ({cmd_take, res_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            tick_reg  <= 16'd0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            nack_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (cmd_take)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            nack_reg  <= nack_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            res_mem[wr_ptr_reg] <= res_in;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // checks
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (i2cm_pkg::RESQ_AW+1)'(i2cm_pkg::RESQ_DEPTH))
        else $error("result queue overfilled");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && done) |=> phase_reg == PH_IDLE)
        else $error("command finished but sequencer still busy");
    a_rej_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && rej) |=> phase_reg == $past(phase_reg) && tick_reg == $past(tick_reg))
        else $error("rejected command disturbed the sequencer");
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && rej) |-> res_in.busy_res && !res_in.done_res)
        else $error("rejection while idle or with done");

endmodule

// ----- hw/rtl/i2c_master_byte_engine.sv -----
// i2c byte engine: one beat per cycle sustained while the result queue has room
// a pushed beat waits in the front queue (4 beats) until the sequencer steps it
// with room in the result queue (2 beats), which registers its result beat
// the sequencer retires one queued beat per cycle while the result queue has room
// reset (rst_n low, asynchronous) empties both queues, idles the bus sequencer with
// scl and sda released, and loads half period 5 and poll limit 15
module i2c_master_byte_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  i2cm_pkg::item_t             item,
    output logic                        empty,
    input  logic                        pop,
    output i2cm_pkg::res_t              result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2cm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    i2cm_pkg::cfg_t cfg;
    i2cm_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_take;

    // configuration registers
    i2cm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // classify and queue
    i2cm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // bus sequencer and result queue
    i2cm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ----- bench/i2c_master_byte_engine_tb.sv -----
// self-checking bench for the i2c byte engine: reset values, directed bus commands, a long
// result stall, then random command/tick sequences with stray codes under random idling
// depends on i2cm_pkg and i2c_master_byte_engine
module i2c_master_byte_engine_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 6;
    localparam int SEQ_GUARD    = 2000;

    // bus sequencer phases of the local predictor
    typedef enum logic [3:0] {
        BUS_IDLE,
        START_A,
        START_B,
        STOP_A,
        STOP_B,
        WR_LOW,
        WR_HIGH,
        WR_ACK_HIGH,
        WR_POLL,
        RD_LOW_FIRST,
        RD_HIGH,
        RD_LOW,
        RD_ACK
    } bus_phase_t;

    logic                          clk;
    logic                          rst_n   = 1'b0;
    logic                          push    = 1'b0;
    logic                          full;
    i2cm_pkg::item_t               item    = '0;
    logic                          empty;
    logic                          pop     = 1'b0;
    i2cm_pkg::res_t                result;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [i2cm_pkg::APB_AW-1:0]   paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // predictor state and its copy of the registers
    bus_phase_t  bus_phase   = BUS_IDLE;
    logic [3:0]  bit_pos     = '0;
    int          phase_ticks = 0;
    logic [7:0]  shift_reg   = '0;
    logic [7:0]  ack_polls   = '0;
    logic        scl_out     = 1'b1;
    logic        sda_out     = 1'b1;
    logic        nack_read   = 1'b0;
    logic        ack_got     = 1'b0;
    logic [7:0]  rx_last     = '0;
    logic [15:0] half_ticks  = i2cm_pkg::HALF_RESET;
    logic [7:0]  poll_limit  = i2cm_pkg::POLL_RESET;

    i2cm_pkg::res_t bus_results_due[$];
    int          err_count   = 0;
    int          cycle_count = 0;
    int          beats_sent  = 0;
    bit          steady      = 1'b0;

    // receiver hold-off request and its own counter
    int          hold_len    = 0;
    int          hold_seq    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    i2c_master_byte_engine dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one scl phase elapsed; zero half period behaves as one
    function automatic bit phase_elapsed();
        int span;
        span = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
        phase_ticks++;
        if (phase_ticks >= span)
        begin
            phase_ticks = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the bus sequence by one tick, returns 1 when the command completes
    function automatic bit advance_bus(logic sda_in);
        int lim;
        bit fin;
        fin = 1'b0;
        lim = (poll_limit == 8'd0) ? 1 : int'(poll_limit);
        case (bus_phase)
            START_A:
                if (phase_elapsed())
                begin
                    sda_out   = 1'b0;
                    bus_phase = START_B;
                end
            START_B:
                if (phase_elapsed())
                begin
                    scl_out   = 1'b0;
                    bus_phase = BUS_IDLE;
                    fin       = 1'b1;
                end
            STOP_A:
                if (phase_elapsed())
                begin
                    sda_out   = 1'b1;
                    bus_phase = STOP_B;
                end
            STOP_B:
                if (phase_elapsed())
                begin
                    scl_out   = 1'b1;
                    sda_out   = 1'b1;
                    bus_phase = BUS_IDLE;
                    fin       = 1'b1;
                end
            WR_LOW:
                if (phase_elapsed())
                begin
                    sda_out   = shift_reg[7];
                    shift_reg = {shift_reg[6:0], 1'b0};
                    scl_out   = 1'b1;
                    bus_phase = WR_HIGH;
                end
            WR_HIGH:
                if (phase_elapsed())
                begin
                    bit_pos = bit_pos + 4'd1;
                    if (bit_pos < 4'd8)
                    begin
                        scl_out   = 1'b0;
                        bus_phase = WR_LOW;
                    end
                    else
                    begin
                        sda_out   = 1'b1;
                        scl_out   = 1'b1;
                        bus_phase = WR_ACK_HIGH;
                    end
                end
            WR_ACK_HIGH:
                if (phase_elapsed())
                begin
                    ack_polls = 8'd0;
                    bus_phase = WR_POLL;
                end
            WR_POLL:
            begin
                // first low sample is an ack, running out of polls is a nack
                if (!sda_in)
                begin
                    ack_got = 1'b1;
                    fin     = 1'b1;
                end
                else
                begin
                    ack_polls = ack_polls + 8'd1;
                    if (int'(ack_polls) >= lim)
                    begin
                        ack_got = 1'b0;
                        fin     = 1'b1;
                    end
                end
                if (fin)
                begin
                    scl_out   = 1'b0;
                    sda_out   = 1'b0;
                    bus_phase = BUS_IDLE;
                end
            end
            RD_LOW_FIRST:
                if (phase_elapsed())
                begin
                    scl_out   = 1'b1;
                    bus_phase = RD_HIGH;
                end
            RD_HIGH:
                if (phase_elapsed())
                begin
                    shift_reg = {shift_reg[6:0], sda_in};
                    scl_out   = 1'b0;
                    bus_phase = RD_LOW;
                end
            RD_LOW:
                if (phase_elapsed())
                begin
                    bit_pos = bit_pos + 4'd1;
                    scl_out = 1'b1;
                    if (bit_pos < 4'd8)
                        bus_phase = RD_HIGH;
                    else
                    begin
                        rx_last   = shift_reg;
                        sda_out   = nack_read;
                        bus_phase = RD_ACK;
                    end
                end
            RD_ACK:
                if (phase_elapsed())
                begin
                    scl_out   = 1'b0;
                    sda_out   = 1'b0;
                    bus_phase = BUS_IDLE;
                    fin       = 1'b1;
                end
            default:
                bus_phase = BUS_IDLE;
        endcase
        return fin;
    endfunction

    // expected result beat for one accepted input beat
    function automatic i2cm_pkg::res_t predict_bus_step(i2cm_pkg::item_t it);
        i2cm_pkg::res_t r;
        bit   fin;
        bit   rej;
        fin = 1'b0;
        rej = 1'b0;
        if (it.func == i2cm_pkg::FUNC_TICK)
        begin
            if (bus_phase != BUS_IDLE)
                fin = advance_bus(it.sda_sample);
        end
        else if (it.func <= i2cm_pkg::FUNC_READ)
        begin
            if (bus_phase != BUS_IDLE)
                rej = 1'b1;
            else
            begin
                phase_ticks = 0;
                bit_pos     = 4'd0;
                case (it.func)
                    i2cm_pkg::FUNC_START:
                    begin
                        scl_out   = 1'b1;
                        sda_out   = 1'b1;
                        bus_phase = START_A;
                    end
                    i2cm_pkg::FUNC_STOP:
                    begin
                        scl_out   = 1'b1;
                        sda_out   = 1'b0;
                        bus_phase = STOP_A;
                    end
                    i2cm_pkg::FUNC_WRITE:
                    begin
                        shift_reg = it.data_byte;
                        scl_out   = 1'b0;
                        bus_phase = WR_LOW;
                    end
                    default:
                    begin
                        shift_reg = 8'd0;
                        nack_read = it.last_byte;
                        sda_out   = 1'b1;
                        scl_out   = 1'b0;
                        bus_phase = RD_LOW_FIRST;
                    end
                endcase
            end
        end
        r.scl_level = scl_out;
        r.sda_level = sda_out;
        r.busy_res  = (bus_phase != BUS_IDLE);
        r.done_res  = fin;
        r.rx_byte   = rx_last;
        r.ack_seen  = ack_got;
        r.rejected  = rej;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic void check_result(i2cm_pkg::res_t got);
        i2cm_pkg::res_t want;
        if (bus_results_due.size() == 0)
        begin
            $error("result beat with nothing expected: %h", got);
            err_count++;
            return;
        end
        want = bus_results_due.pop_front();
        check_field("scl_level", int'(want.scl_level), int'(got.scl_level));
        check_field("sda_level", int'(want.sda_level), int'(got.sda_level));
        check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
        check_field("done_res", int'(want.done_res), int'(got.done_res));
        check_field("rx_byte", int'(want.rx_byte), int'(got.rx_byte));
        check_field("ack_seen", int'(want.ack_seen), int'(got.ack_seen));
        check_field("rejected", int'(want.rejected), int'(got.rejected));
    endfunction

    // result side: check each accepted beat, random pop with hold-off on request
    always @(posedge clk)
    begin
        if (pop && !empty)
            check_result(result);
        if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            pop       <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end
        else
            pop <= rst_n && (steady || $urandom_range(99) >= 13);
    end

    // send one beat, with random gaps before it unless steady, and record its expected result
    task automatic send_beat(input logic [2:0] fn, input logic [7:0] data,
                             input logic last, input logic sda);
        i2cm_pkg::item_t it;
        it.func       = fn;
        it.data_byte  = data;
        it.last_byte  = last;
        it.sda_sample = sda;
        if (!steady)
            while ($urandom_range(99) < 13)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        bus_results_due.push_back(predict_bus_step(it));
        if (fn <= i2cm_pkg::FUNC_READ)
            beats_sent++;
    endtask

    // ticks until the predicted sequencer is idle; bias is the chance in percent
    // of a high sda sample; noisy mixes in commands while busy and unknown codes
    task automatic tick_until_idle(input int bias, input bit noisy);
        int guard;
        guard = 0;
        while (bus_phase != BUS_IDLE && guard < SEQ_GUARD)
        begin
            if (noisy && $urandom_range(99) < 5)
                send_beat(3'($urandom_range(7, 1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_beat(i2cm_pkg::FUNC_TICK, 8'($urandom_range(255)),
                          1'($urandom_range(1)), $urandom_range(99) < bias);
            guard++;
        end
    endtask

    // stop sending and wait for every expected beat plus the pipeline tail
    task automatic wait_drained();
        push <= 1'b0;
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic read_reg(input logic idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        check_field(idx == i2cm_pkg::REG_POLL ? "ack_poll_limit" : "half_period_ticks",
                    int'(want), int'(got));
    endtask

    // register write with read-back; only called with the block drained
    task automatic write_reg(input logic idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == i2cm_pkg::REG_POLL)
            poll_limit = value[7:0];
        else
            half_ticks = value[15:0];
        read_reg(idx, idx == i2cm_pkg::REG_POLL ? 32'(poll_limit) : 32'(half_ticks));
    endtask

    task automatic set_timing(input int half, input int polls);
        wait_drained();
        write_reg(i2cm_pkg::REG_HALF, half);
        write_reg(i2cm_pkg::REG_POLL, polls);
    endtask

    task automatic test_reset_values();
        read_reg(i2cm_pkg::REG_HALF, 32'(i2cm_pkg::HALF_RESET));
        read_reg(i2cm_pkg::REG_POLL, 32'(i2cm_pkg::POLL_RESET));
    endtask

    // idle ticks, unknown codes, each command, a rejected command, ack and nack
    task automatic test_directed_commands();
        set_timing(1, 2);
        send_beat(i2cm_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0);
        send_beat(i2cm_pkg::FUNC_TICK, 8'hFF, 1'b1, 1'b1);
        send_beat(3'd5, 8'hFF, 1'b1, 1'b1);
        send_beat(3'd6, 8'h00, 1'b0, 1'b0);
        send_beat(3'd7, 8'hFF, 1'b1, 1'b1);
        send_beat(i2cm_pkg::FUNC_START, 8'h00, 1'b0, 1'b0);
        send_beat(i2cm_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1);
        send_beat(i2cm_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b1);
        send_beat(i2cm_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0);
        send_beat(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0, 1'b0);
        tick_until_idle(50, 1'b0);
        // write all ones acked on the first poll, all zeros never acked
        send_beat(i2cm_pkg::FUNC_WRITE, 8'hFF, 1'b0, 1'b0);
        tick_until_idle(0, 1'b0);
        send_beat(i2cm_pkg::FUNC_WRITE, 8'h00, 1'b0, 1'b0);
        tick_until_idle(100, 1'b0);
        // reads with nack and with ack
        send_beat(i2cm_pkg::FUNC_READ, 8'h00, 1'b1, 1'b0);
        tick_until_idle(100, 1'b0);
        send_beat(i2cm_pkg::FUNC_READ, 8'hFF, 1'b0, 1'b1);
        tick_until_idle(0, 1'b0);
    endtask

    // longest ack poll ending in nack
    task automatic test_poll_timeout();
        set_timing(1, 255);
        send_beat(i2cm_pkg::FUNC_WRITE, 8'h5A, 1'b0, 1'b0);
        tick_until_idle(100, 1'b0);
    endtask

    // longest half period: a start that does not finish here, stop rejected
    task automatic test_slow_half_period();
        set_timing(65535, 1);
        send_beat(i2cm_pkg::FUNC_START, 8'h00, 1'b0, 1'b0);
        repeat (5) send_beat(i2cm_pkg::FUNC_TICK, 8'($urandom_range(255)), 1'b0,
                             1'($urandom_range(1)));
        send_beat(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    // result side stalls long while beats keep coming, then a full drain
    task automatic test_backpressure();
        int base;
        set_timing(2, 3);
        base = beats_sent;
        hold_len <= 60;
        hold_seq <= hold_seq + 1;
        steady = 1'b1;
        while (beats_sent < base + 140)
        begin
            send_beat(3'($urandom_range(4, 1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'b0);
            tick_until_idle(int'($urandom_range(100)), 1'b1);
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // random command sequences over several timing settings
    task automatic test_random_sequences();
        int halves [6] = '{1, 2, 3, 0, 1, 2};
        int polls  [6] = '{1, 4, 255, 0, 15, 1};
        int target;
        for (int k = 0; k < 6; k++)
        begin
            set_timing(halves[k], polls[k]);
            steady = (k == 4);
            target = beats_sent + 250;
            while (beats_sent < target)
            begin
                if ($urandom_range(99) < 85)
                begin
                    send_beat(3'($urandom_range(4, 1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                    tick_until_idle(int'($urandom_range(100)), 1'b1);
                end
                else if ($urandom_range(1) == 1)
                    send_beat(i2cm_pkg::FUNC_TICK, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                    send_beat(3'($urandom_range(7, 5)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        steady = 1'b0;
    endtask

    // main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_commands();
        test_poll_timeout();
        test_slow_half_period();
        test_backpressure();
        test_random_sequences();
        wait_drained();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_cfg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_back.sv
hw/rtl/i2c_master_byte_engine.sv
bench/i2c_master_byte_engine_tb.sv
